### sv/aif_pkg.sv
// ----------------------------------------------------------------------------
// aif_pkg
// Shared types and constants of the infrared frame decoder.
// ----------------------------------------------------------------------------
package aif_pkg;

    localparam int DUR_W      = 16;
    localparam int UNIT_W     = 11;
    localparam int TOL_W      = 7;
    localparam int NOM_W      = 14;   // unit times eight
    localparam int FAC_W      = 8;    // 100 plus tolerance
    localparam int PROD_W     = NOM_W + FAC_W;
    localparam int SCALED_W   = 23;   // duration times 100, plus 99
    localparam int NWIN       = 4;
    localparam int SEQ_W      = 3;    // one step per bound, two bounds per window
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int BITPOS_W   = 4;
    localparam int BYTES_W    = 6;
    localparam int VALUE_W    = 16;
    localparam int MAX_DATA_BYTES = 35;

    localparam logic [TOL_W-1:0]    TOL_MAX   = 7'd100;
    localparam logic [FAC_W-1:0]    PCT_SCALE = 8'd100;
    localparam logic [SCALED_W-1:0] PCT_MUL   = 23'd100;
    localparam logic [SCALED_W-1:0] PCT_ROUND = 23'd99;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 11'd425;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 7'd25;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_US = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_PCT = 4'd1;

    // tolerance windows
    localparam logic [1:0] WIN_X8 = 2'd0;
    localparam logic [1:0] WIN_X4 = 2'd1;
    localparam logic [1:0] WIN_X3 = 2'd2;
    localparam logic [1:0] WIN_X1 = 2'd3;

    // pulse kinds
    localparam logic [1:0] PK_MARK  = 2'd0;
    localparam logic [1:0] PK_SPACE = 2'd1;

    // result kinds
    localparam logic [1:0] RK_ADDR = 2'd0;
    localparam logic [1:0] RK_BYTE = 2'd1;
    localparam logic [1:0] RK_OK   = 2'd2;
    localparam logic [1:0] RK_ERR  = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR_SPACE,
        PH_ADDR_MARK,
        PH_ADDR_SPACE,
        PH_DATA_MARK,
        PH_DATA_SPACE,
        PH_DRAIN
    } t_phase;

    typedef struct packed {
        logic [NWIN-1:0][PROD_W-1:0] lo;
        logic [NWIN-1:0][PROD_W-1:0] hi;
    } t_thr;

    typedef struct packed {
        logic is_mark;
        logic is_space;
        logic is_end;
        logic m8;
        logic m4;
        logic m3;
        logic m1;
    } t_cls;

    typedef struct packed {
        logic [1:0]         kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_result;

endpackage

### sv/aif_cfg.sv
// ----------------------------------------------------------------------------
// aif_cfg
// Configuration registers and the sequencer that derives window thresholds.
// ----------------------------------------------------------------------------
module aif_cfg import aif_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_busy,
    output t_thr                  o_thr
);

    logic [UNIT_W-1:0] r_unit;
    logic [TOL_W-1:0]  r_tol;
    logic              r_busy;
    logic [SEQ_W-1:0]  r_idx;
    logic [PROD_W-1:0] r_lo [NWIN];
    logic [PROD_W-1:0] r_hi [NWIN];

    logic [TOL_W-1:0]  tol_c;
    logic [NOM_W-1:0]  nom;
    logic [FAC_W-1:0]  fac;
    logic [PROD_W-1:0] prod;
    logic [1:0]        win;

    assign win   = r_idx[SEQ_W-1:1];
    assign tol_c = (r_tol > TOL_MAX) ? TOL_MAX : r_tol;

    always_comb begin
        case (win)
            WIN_X8:  nom = {r_unit, 3'b000};
            WIN_X4:  nom = {1'b0, r_unit, 2'b00};
            WIN_X3:  nom = NOM_W'({r_unit, 1'b0}) + NOM_W'(r_unit);
            default: nom = NOM_W'(r_unit);
        endcase
    end

    assign fac  = r_idx[0] ? (PCT_SCALE + FAC_W'(tol_c)) : (PCT_SCALE - FAC_W'(tol_c));
    assign prod = PROD_W'(nom) * PROD_W'(fac);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= UNIT_RESET;
            r_tol  <= TOL_RESET;
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_UNIT_US) begin
                r_unit <= i_cfg_data[UNIT_W-1:0];
            end else if (i_cfg_index == CFG_TOL_PCT) begin
                r_tol <= i_cfg_data[TOL_W-1:0];
            end
            // restart the threshold sweep with the new values
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            r_idx <= r_idx + SEQ_W'(1);
            if (r_idx == '1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !i_cfg_valid) begin
            if (r_idx[0]) begin
                r_hi[win] <= prod;
            end else begin
                r_lo[win] <= prod;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NWIN; k++) begin
            o_thr.lo[k] = r_lo[k];
            o_thr.hi[k] = r_hi[k];
        end
    end

    assign o_busy = r_busy;

endmodule

### sv/aif_front.sv
// ----------------------------------------------------------------------------
// aif_front
// Accepts pulses, classifies them against the windows, queues the result.
// ----------------------------------------------------------------------------
module aif_front import aif_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [1:0]       i_pulse_kind,
    input  logic [DUR_W-1:0] i_duration_us,
    input  t_thr             i_thr,
    input  logic             i_deq,
    output logic             o_qfull,
    output logic             o_qvalid,
    output t_cls             o_cls
);

    t_cls          r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;

    logic [SCALED_W-1:0] d100;
    logic [SCALED_W-1:0] d100r;
    logic [NWIN-1:0]     hit;
    t_cls                cls;

    // floor(p/100) <= d  <=>  100*d + 99 >= p ;  d <= floor(q/100)  <=>  100*d <= q
    assign d100  = SCALED_W'(i_duration_us) * PCT_MUL;
    assign d100r = d100 + PCT_ROUND;

    always_comb begin
        for (int k = 0; k < NWIN; k++) begin
            hit[k] = (d100r >= SCALED_W'(i_thr.lo[k])) && (d100 <= SCALED_W'(i_thr.hi[k]));
        end
    end

    always_comb begin
        cls.is_mark  = (i_pulse_kind == PK_MARK);
        cls.is_space = (i_pulse_kind == PK_SPACE);
        cls.is_end   = !(i_pulse_kind == PK_MARK) && !(i_pulse_kind == PK_SPACE);
        cls.m8       = hit[WIN_X8];
        cls.m4       = hit[WIN_X4];
        cls.m3       = hit[WIN_X3];
        cls.m1       = hit[WIN_X1];
    end

    assign n_cnt = r_cnt + {1'b0, i_accept} - {1'b0, i_deq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_accept) begin
                r_wp <= ~r_wp;
            end
            if (i_deq) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_q[r_wp] <= cls;
        end
    end

    assign o_qfull  = (r_cnt == 2'd2);
    assign o_qvalid = (r_cnt != 2'd0);
    assign o_cls    = r_q[r_rp];

endmodule

### sv/aif_back.sv
// ----------------------------------------------------------------------------
// aif_back
// Frame state machine and result queue.
// ----------------------------------------------------------------------------
module aif_back import aif_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_qvalid,
    input  t_cls i_cls,
    input  logic i_pop,
    output logic o_deq,
    output logic o_empty,
    output t_result o_res
);

    t_phase              r_phase;
    t_phase              n_phase;
    logic [BITPOS_W-1:0] r_bitpos;
    logic [BITPOS_W-1:0] n_bitpos;
    logic [VALUE_W-1:0]  r_shift;
    logic [VALUE_W-1:0]  n_shift;
    logic [BYTES_W-1:0]  r_bytes;
    logic [BYTES_W-1:0]  n_bytes;

    t_result    r_oq [2];
    logic       r_owp;
    logic       r_orp;
    logic [1:0] r_ocnt;

    logic    step;
    logic    res_valid;
    t_result res;
    logic    bit_ok;
    logic    bit_val;
    logic    at_limit;
    logic    out_take;
    t_phase  fin_phase;
    logic [VALUE_W-1:0] sw16;
    logic [VALUE_W-1:0] sw8;

    assign step      = i_qvalid && (r_ocnt != 2'd2);
    assign out_take  = i_pop && (r_ocnt != 2'd0);
    assign bit_ok    = i_cls.is_space && (i_cls.m3 || i_cls.m1);
    assign bit_val   = i_cls.is_space && i_cls.m3;   // one wins where windows overlap
    assign at_limit  = (r_bytes >= BYTES_W'(MAX_DATA_BYTES));
    assign fin_phase = i_cls.is_end ? PH_IDLE : PH_DRAIN;
    assign sw16      = {r_shift[VALUE_W-2:0], bit_val};
    assign sw8       = {8'h00, r_shift[6:0], bit_val};

    // next state
    always_comb begin
        n_phase = r_phase;
        if (step) begin
            case (r_phase)
                PH_IDLE: begin
                    if (!i_cls.is_end) begin
                        n_phase = (i_cls.is_mark && i_cls.m8) ? PH_HDR_SPACE : PH_DRAIN;
                    end
                end
                PH_HDR_SPACE: begin
                    n_phase = (i_cls.is_space && i_cls.m4) ? PH_ADDR_MARK : fin_phase;
                end
                PH_ADDR_MARK: begin
                    n_phase = (i_cls.is_mark && i_cls.m1) ? PH_ADDR_SPACE : fin_phase;
                end
                PH_ADDR_SPACE: begin
                    if (bit_ok) begin
                        n_phase = (r_bitpos >= 4'd15) ? PH_DATA_MARK : PH_ADDR_MARK;
                    end else begin
                        n_phase = fin_phase;
                    end
                end
                PH_DATA_MARK: begin
                    if (i_cls.is_mark && i_cls.m1) begin
                        n_phase = at_limit ? PH_DRAIN : PH_DATA_SPACE;
                    end else begin
                        n_phase = fin_phase;
                    end
                end
                PH_DATA_SPACE: begin
                    n_phase = bit_ok ? PH_DATA_MARK : fin_phase;
                end
                PH_DRAIN: begin
                    if (i_cls.is_end) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // outputs and datapath
    always_comb begin
        n_bitpos  = r_bitpos;
        n_shift   = r_shift;
        n_bytes   = r_bytes;
        res_valid = 1'b0;
        res.kind  = RK_ERR;
        res.value = '0;
        res.last  = 1'b1;
        if (step) begin
            case (r_phase)
                PH_IDLE: begin
                    if (!i_cls.is_end && !(i_cls.is_mark && i_cls.m8)) begin
                        res_valid = 1'b1;
                    end
                end
                PH_HDR_SPACE: begin
                    if (i_cls.is_space && i_cls.m4) begin
                        n_bitpos = '0;
                        n_shift  = '0;
                    end else begin
                        res_valid = 1'b1;
                    end
                end
                PH_ADDR_MARK: begin
                    if (!(i_cls.is_mark && i_cls.m1)) begin
                        res_valid = 1'b1;
                    end
                end
                PH_ADDR_SPACE: begin
                    if (!bit_ok) begin
                        res_valid = 1'b1;
                    end else if (r_bitpos >= 4'd15) begin
                        res_valid = 1'b1;
                        res.kind  = RK_ADDR;
                        res.value = sw16;
                        res.last  = 1'b0;
                        n_bitpos  = '0;
                        n_shift   = '0;
                        n_bytes   = '0;
                    end else begin
                        n_bitpos = r_bitpos + 4'd1;
                        n_shift  = sw16;
                    end
                end
                PH_DATA_MARK: begin
                    if (!(i_cls.is_mark && i_cls.m1)) begin
                        res_valid = 1'b1;
                    end else if (at_limit) begin
                        res_valid = 1'b1;
                        res.kind  = RK_OK;
                    end
                end
                PH_DATA_SPACE: begin
                    if (!bit_ok) begin
                        // frame end: fine once two bytes are in, partial byte dropped
                        res_valid = 1'b1;
                        res.kind  = (r_bytes >= 6'd2) ? RK_OK : RK_ERR;
                    end else if (r_bitpos >= 4'd7) begin
                        res_valid = 1'b1;
                        res.kind  = RK_BYTE;
                        res.value = sw8;
                        res.last  = 1'b0;
                        n_bitpos  = '0;
                        n_shift   = '0;
                        n_bytes   = r_bytes + 6'd1;
                    end else begin
                        n_bitpos = r_bitpos + 4'd1;
                        n_shift  = sw8;
                    end
                end
                default: begin
                end
            endcase
            // any ending result clears the frame state
            if (res_valid && res.last) begin
                n_bitpos = '0;
                n_shift  = '0;
                n_bytes  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_bitpos <= '0;
            r_shift  <= '0;
            r_bytes  <= '0;
            r_owp    <= 1'b0;
            r_orp    <= 1'b0;
            r_ocnt   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_bitpos <= n_bitpos;
            r_shift  <= n_shift;
            r_bytes  <= n_bytes;
            if (step && res_valid) begin
                r_owp <= ~r_owp;
            end
            if (out_take) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + {1'b0, step && res_valid} - {1'b0, out_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_oq[r_owp] <= res;
        end
    end

    assign o_deq   = step;
    assign o_empty = (r_ocnt == 2'd0);
    assign o_res   = r_oq[r_orp];

endmodule

### sv/aeha_ir_frame_decoder.sv
// ----------------------------------------------------------------------------
// aeha_ir_frame_decoder
// Infrared remote frame decoder: header, 16-bit address, up to 35 data bytes.
// ----------------------------------------------------------------------------
// Takes one pulse per clock cycle when full is low, sustained. A pulse is
// classified against the tolerance windows in the cycle it is pushed, waits in
// a two-entry queue, and the frame state machine turns it into at most one
// result, which is registered into a two-entry queue of its own. After reset
// and after every configuration write, full stays high while one shared
// multiplier recomputes the eight window bounds, one per cycle; a further
// write restarts the sweep.
module aeha_ir_frame_decoder import aif_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            i_pulse_kind,
    input  logic [DUR_W-1:0]      i_duration_us,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            o_result_kind,
    output logic [VALUE_W-1:0]    o_value,
    output logic                  o_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    busy;
    t_thr    thr;
    logic    accept;
    logic    qfull;
    logic    qvalid;
    logic    deq;
    t_cls    cls;
    t_result res;

    assign o_cfg_ready = 1'b1;
    assign full        = busy || qfull;
    assign accept      = push && !full;

    aif_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (busy),
        .o_thr       (thr)
    );

    aif_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_pulse_kind  (i_pulse_kind),
        .i_duration_us (i_duration_us),
        .i_thr         (thr),
        .i_deq         (deq),
        .o_qfull       (qfull),
        .o_qvalid      (qvalid),
        .o_cls         (cls)
    );

    aif_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (qvalid),
        .i_cls    (cls),
        .i_pop    (pop),
        .o_deq    (deq),
        .o_empty  (empty),
        .o_res    (res)
    );

    assign o_result_kind = res.kind;
    assign o_value       = res.value;
    assign o_last        = res.last;

endmodule

### sv/aif_checker.sv
// ----------------------------------------------------------------------------
// aif_checker
// Port-level checks of the infrared frame decoder.
// ----------------------------------------------------------------------------
module aif_checker import aif_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  push,
    input logic                  full,
    input logic [1:0]            i_pulse_kind,
    input logic [DUR_W-1:0]      i_duration_us,
    input logic                  empty,
    input logic                  pop,
    input logic [1:0]            o_result_kind,
    input logic [VALUE_W-1:0]    o_value,
    input logic                  o_last,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // reset leaves no result and holds off input while thresholds are built
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && full)
        else $error("decoder not empty and blocked after reset");

    // ok and error carry last and a zero value, address and byte never carry last
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last == (o_result_kind == RK_OK || o_result_kind == RK_ERR))
                   && (!o_last || o_value == '0))
        else $error("last flag does not match result kind");

    // a data byte fits in the low eight bits
    a_byte_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result_kind == RK_BYTE |-> o_value[15:8] == 8'h00)
        else $error("data byte wider than eight bits");

    // a stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result_kind) && $stable(o_value)
                           && $stable(o_last))
        else $error("waiting result changed");

    // a register write blocks input while windows are recomputed
    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> full)
        else $error("input open right after configuration write");

endmodule

bind aeha_ir_frame_decoder aif_checker u_aif_checker (.*);
